FILE: rtl/core/imvn_pkg.sv
`timescale 1ns / 1ps
package imvn_pkg;
    localparam int DEF_VERTEX_COUNT = 1024;
    localparam int DEF_COORD_WIDTH = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam int OP_W = 2;
    localparam int IDX_W = 10;
    localparam int NRM_W = 16;
    localparam int SUM_W = 24;
    localparam int VEC_W = 64;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_TRI = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] K_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] K_TRI = 2'd1;
    localparam logic [KIND_W-1:0] K_READ = 2'd2;
    localparam logic [KIND_W-1:0] K_BADREAD = 2'd3;

    localparam logic [NRM_W-1:0] ONE_Q14 = 16'd16384;
    localparam logic signed [SUM_W:0] SUM_MAX = 25'sd8388607;
    localparam logic signed [SUM_W:0] SUM_MIN = -25'sd8388608;
    localparam logic [VEC_W-1:0] RED_LIMIT = 64'd1 << 30;
endpackage

FILE: rtl/core/imvn_front.sv
`timescale 1ns / 1ps
module imvn_front #(
    parameter int VERTEX_COUNT = imvn_pkg::DEF_VERTEX_COUNT
) (
    input  logic [imvn_pkg::OP_W-1:0]   opcode,
    input  logic [imvn_pkg::IDX_W-1:0]  vertex_index,
    input  logic [imvn_pkg::IDX_W-1:0]  corner_a,
    input  logic [imvn_pkg::IDX_W-1:0]  corner_b,
    input  logic [imvn_pkg::IDX_W-1:0]  corner_c,
    output logic [imvn_pkg::KIND_W-1:0] kind,
    output logic [imvn_pkg::IDX_W-1:0]  index0,
    output logic                        keep
);
    logic vi_ok;
    logic tri_ok;

    assign vi_ok = {22'd0, vertex_index} < 32'(VERTEX_COUNT);
    assign tri_ok = ({22'd0, corner_a} < 32'(VERTEX_COUNT))
                 && ({22'd0, corner_b} < 32'(VERTEX_COUNT))
                 && ({22'd0, corner_c} < 32'(VERTEX_COUNT));

    always_comb
    begin
        kind = imvn_pkg::K_WRITE;
        index0 = vertex_index;
        keep = 1'b0;
        unique case (opcode)
            imvn_pkg::OP_WRITE:
            begin
                kind = imvn_pkg::K_WRITE;
                keep = vi_ok;
            end
            imvn_pkg::OP_TRI:
            begin
                kind = imvn_pkg::K_TRI;
                index0 = corner_a;
                keep = tri_ok;
            end
            imvn_pkg::OP_READ:
            begin
                kind = vi_ok ? imvn_pkg::K_READ : imvn_pkg::K_BADREAD;
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end
endmodule

FILE: rtl/core/imvn_queue.sv
`timescale 1ns / 1ps
module imvn_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = imvn_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty,
    output logic             full
);
    localparam int PW = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_reg;
    logic [PW-1:0]    rd_reg;
    logic [CNW-1:0]   count_reg;

    assign empty = count_reg == '0;
    assign full = count_reg == CNW'(DEPTH);
    assign dout = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNW'(1);
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("Queue written while full.");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("Queue read while empty.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNW'(1)))
        else $error("Queue count lost a transfer.");
endmodule

FILE: rtl/core/imvn_norm.sv
`timescale 1ns / 1ps
module imvn_norm (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [imvn_pkg::VEC_W-1:0] vx,
    input  logic signed [imvn_pkg::VEC_W-1:0] vy,
    input  logic signed [imvn_pkg::VEC_W-1:0] vz,
    output logic                              done,
    output logic signed [imvn_pkg::NRM_W-1:0] nx,
    output logic signed [imvn_pkg::NRM_W-1:0] ny,
    output logic signed [imvn_pkg::NRM_W-1:0] nz,
    output logic                              ok
);
    localparam logic [2:0] N_IDLE = 3'd0;
    localparam logic [2:0] N_RED = 3'd1;
    localparam logic [2:0] N_SQ = 3'd2;
    localparam logic [2:0] N_SQRT = 3'd3;
    localparam logic [2:0] N_CHK = 3'd4;
    localparam logic [2:0] N_DINIT = 3'd5;
    localparam logic [2:0] N_DIV = 3'd6;
    localparam logic [2:0] N_DSTORE = 3'd7;

    logic [2:0]  state_reg;
    logic        sgn_reg [3];
    logic [63:0] mag_reg [3];
    logic [1:0]  comp_reg;
    logic [63:0] acc_reg;
    logic [63:0] rad_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [44:0] num_reg;
    logic [31:0] rem_reg;
    logic [44:0] quo_reg;
    logic [5:0]  step_reg;
    logic signed [15:0] n_reg [3];
    logic        ok_reg;
    logic        done_reg;

    logic signed [63:0] vin [3];
    logic        big;
    logic [29:0] mag_sel;
    logic [59:0] sq;
    logic [63:0] trial;
    logic [32:0] rem_sh;
    logic        qbit;
    logic [15:0] qclamp;

    assign vin[0] = vx;
    assign vin[1] = vy;
    assign vin[2] = vz;
    assign big = (mag_reg[0] >= imvn_pkg::RED_LIMIT) || (mag_reg[1] >= imvn_pkg::RED_LIMIT)
              || (mag_reg[2] >= imvn_pkg::RED_LIMIT);
    assign mag_sel = mag_reg[comp_reg][29:0];
    assign sq = mag_sel * mag_sel;
    assign trial = res_reg + bit_reg;
    assign rem_sh = {rem_reg, num_reg[44]};
    assign qbit = rem_sh >= {1'b0, res_reg[31:0]};
    assign qclamp = (quo_reg > 45'(imvn_pkg::ONE_Q14)) ? imvn_pkg::ONE_Q14 : quo_reg[15:0];

    assign done = done_reg;
    assign nx = n_reg[0];
    assign ny = n_reg[1];
    assign nz = n_reg[2];
    assign ok = ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg <= 1'b0;
            ok_reg <= 1'b0;
            comp_reg <= '0;
            acc_reg <= '0;
            rad_reg <= '0;
            res_reg <= '0;
            bit_reg <= '0;
            num_reg <= '0;
            rem_reg <= '0;
            quo_reg <= '0;
            step_reg <= '0;
            for (int k = 0; k < 3; k++)
            begin
                sgn_reg[k] <= 1'b0;
                mag_reg[k] <= '0;
                n_reg[k] <= '0;
            end
        end
        else
        begin
            done_reg <= ((state_reg == N_CHK) && (res_reg == '0))
                     || ((state_reg == N_DSTORE) && (comp_reg == 2'd2));
            unique case (state_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            sgn_reg[k] <= vin[k][63];
                            mag_reg[k] <= vin[k][63] ? (~vin[k] + 64'd1) : vin[k];
                        end
                        state_reg <= N_RED;
                    end
                end
                N_RED:
                begin
                    if (big)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            mag_reg[k] <= mag_reg[k] >> 1;
                        end
                    end
                    else
                    begin
                        acc_reg <= '0;
                        comp_reg <= '0;
                        state_reg <= N_SQ;
                    end
                end
                N_SQ:
                begin
                    acc_reg <= acc_reg + 64'(sq);
                    comp_reg <= comp_reg + 2'd1;
                    if (comp_reg == 2'd2)
                    begin
                        rad_reg <= acc_reg + 64'(sq);
                        res_reg <= '0;
                        bit_reg <= 64'd1 << 62;
                        state_reg <= N_SQRT;
                    end
                end
                N_SQRT:
                begin
                    if (rad_reg >= trial)
                    begin
                        rad_reg <= rad_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg == 64'd1)
                    begin
                        state_reg <= N_CHK;
                    end
                end
                N_CHK:
                begin
                    if (res_reg == '0)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            n_reg[k] <= '0;
                        end
                        ok_reg <= 1'b0;
                        state_reg <= N_IDLE;
                    end
                    else
                    begin
                        comp_reg <= '0;
                        state_reg <= N_DINIT;
                    end
                end
                N_DINIT:
                begin
                    num_reg <= {1'b0, mag_sel, 14'd0} + {14'd0, res_reg[31:1]};
                    rem_reg <= '0;
                    quo_reg <= '0;
                    step_reg <= '0;
                    state_reg <= N_DIV;
                end
                N_DIV:
                begin
                    rem_reg <= qbit ? 32'(rem_sh - {1'b0, res_reg[31:0]}) : rem_sh[31:0];
                    quo_reg <= {quo_reg[43:0], qbit};
                    num_reg <= num_reg << 1;
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd44)
                    begin
                        state_reg <= N_DSTORE;
                    end
                end
                N_DSTORE:
                begin
                    n_reg[comp_reg] <= sgn_reg[comp_reg] ? -$signed(qclamp) : $signed(qclamp);
                    if (comp_reg == 2'd2)
                    begin
                        ok_reg <= 1'b1;
                        state_reg <= N_IDLE;
                    end
                    else
                    begin
                        comp_reg <= comp_reg + 2'd1;
                        state_reg <= N_DINIT;
                    end
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end
endmodule

FILE: rtl/core/imvn_back.sv
`timescale 1ns / 1ps
module imvn_back #(
    parameter int VERTEX_COUNT = imvn_pkg::DEF_VERTEX_COUNT,
    parameter int COORD_WIDTH = imvn_pkg::DEF_COORD_WIDTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic q_empty,
    input  logic [imvn_pkg::KIND_W+3*imvn_pkg::IDX_W+3*COORD_WIDTH-1:0] q_dout,
    output logic q_pop,
    output logic out_valid,
    input  logic out_stall,
    output logic signed [imvn_pkg::NRM_W-1:0] normal_x,
    output logic signed [imvn_pkg::NRM_W-1:0] normal_y,
    output logic signed [imvn_pkg::NRM_W-1:0] normal_z,
    output logic normal_valid
);
    localparam int AW = $clog2(VERTEX_COUNT);
    localparam int CW = COORD_WIDTH;
    localparam int EW = CW + 1;
    localparam int PW = 3 * CW;
    localparam int IW = imvn_pkg::IDX_W;
    localparam int KW = imvn_pkg::KIND_W;
    localparam int QW = KW + 3 * IW + PW;
    localparam int SW = imvn_pkg::SUM_W;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_SREAD = 4'd2;
    localparam logic [3:0] S_T0 = 4'd3;
    localparam logic [3:0] S_T1 = 4'd4;
    localparam logic [3:0] S_T2 = 4'd5;
    localparam logic [3:0] S_T3 = 4'd6;
    localparam logic [3:0] S_ERED = 4'd7;
    localparam logic [3:0] S_MUL = 4'd8;
    localparam logic [3:0] S_NORM = 4'd9;
    localparam logic [3:0] S_ACCR = 4'd10;
    localparam logic [3:0] S_ACCW = 4'd11;
    localparam logic [3:0] S_OUT = 4'd12;
    localparam logic [3:0] S_NSTART = 4'd13;

    logic [PW-1:0]   vert_mem [VERTEX_COUNT];
    logic [3*SW-1:0] sum_mem [VERTEX_COUNT];
    logic [PW-1:0]   vrd_reg;
    logic [3*SW-1:0] srd_reg;

    logic [3:0]    state_reg;
    logic [AW-1:0] clr_reg;
    logic [KW-1:0] kind_reg;
    logic [IW-1:0] ia_reg;
    logic [IW-1:0] ib_reg;
    logic [IW-1:0] ic_reg;
    logic [PW-1:0] pa_reg;
    logic [PW-1:0] pb_reg;
    logic          e1s_reg [3];
    logic [EW-1:0] e1m_reg [3];
    logic          e2s_reg [3];
    logic [EW-1:0] e2m_reg [3];
    logic [1:0]    mul_reg;
    logic [1:0]    corner_reg;
    logic signed [61:0] prod0_reg;
    logic signed [61:0] prod1_reg;
    logic signed [63:0] cr_reg [3];
    logic          out_valid_reg;
    logic signed [15:0] out_x_reg;
    logic signed [15:0] out_y_reg;
    logic signed [15:0] out_z_reg;
    logic          out_ok_reg;

    logic [KW-1:0] q_kind;
    logic [IW-1:0] q_i0;
    logic [IW-1:0] q_i1;
    logic [IW-1:0] q_i2;
    logic [PW-1:0] q_pos;
    logic          v_we;
    logic [AW-1:0] v_addr;
    logic          s_we;
    logic [AW-1:0] s_addr;
    logic [3*SW-1:0] s_wdata;
    logic          norm_start;
    logic          norm_sel_sum;
    logic signed [63:0] nv [3];
    logic          norm_done;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic          nok;
    logic signed [30:0] e1v [3];
    logic signed [30:0] e2v [3];
    logic signed [30:0] op_a;
    logic signed [30:0] op_b;
    logic signed [30:0] op_c;
    logic signed [30:0] op_d;
    logic signed [63:0] cr_next;
    logic          big1;
    logic          big2;
    logic [IW-1:0] corner_idx;
    logic          out_load;

    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [15:0] b);
        logic signed [SW:0] s;
        s = $signed({a[SW-1], a}) + $signed({{(SW-15){b[15]}}, b});
        if (s > imvn_pkg::SUM_MAX)
        begin
            s = imvn_pkg::SUM_MAX;
        end
        else if (s < imvn_pkg::SUM_MIN)
        begin
            s = imvn_pkg::SUM_MIN;
        end
        return s[SW-1:0];
    endfunction

    function automatic logic signed [EW-1:0] coord_ext(input logic [PW-1:0] w, input int k);
        logic [CW-1:0] c;
        c = w[(3 - k) * CW - 1 -: CW];
        return $signed({c[CW-1], c});
    endfunction

    function automatic logic signed [30:0] sval(input logic s, input logic [EW-1:0] m);
        logic signed [30:0] v;
        v = $signed({1'b0, 30'(m)});
        return s ? -v : v;
    endfunction

    assign q_kind = q_dout[QW-1 -: KW];
    assign q_i0 = q_dout[PW+3*IW-1 -: IW];
    assign q_i1 = q_dout[PW+2*IW-1 -: IW];
    assign q_i2 = q_dout[PW+IW-1 -: IW];
    assign q_pos = q_dout[PW-1:0];

    assign corner_idx = (corner_reg == 2'd0) ? ia_reg : (corner_reg == 2'd1) ? ib_reg : ic_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            e1v[k] = sval(e1s_reg[k], e1m_reg[k]);
            e2v[k] = sval(e2s_reg[k], e2m_reg[k]);
        end
        big1 = 1'b0;
        big2 = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            big1 = big1 | (64'(e1m_reg[k]) >= imvn_pkg::RED_LIMIT);
            big2 = big2 | (64'(e2m_reg[k]) >= imvn_pkg::RED_LIMIT);
        end
    end

    always_comb
    begin
        op_a = e1v[1];
        op_b = e2v[2];
        op_c = e1v[2];
        op_d = e2v[1];
        unique case (mul_reg)
            2'd1:
            begin
                op_a = e1v[2];
                op_b = e2v[0];
                op_c = e1v[0];
                op_d = e2v[2];
            end
            2'd2:
            begin
                op_a = e1v[0];
                op_b = e2v[1];
                op_c = e1v[1];
                op_d = e2v[0];
            end
            default:
            begin
                op_a = e1v[1];
                op_b = e2v[2];
                op_c = e1v[2];
                op_d = e2v[1];
            end
        endcase
    end

    assign cr_next = $signed({{2{prod0_reg[61]}}, prod0_reg})
                   - $signed({{2{prod1_reg[61]}}, prod1_reg});

    assign nv[0] = norm_sel_sum ? $signed({{(64-SW){srd_reg[3*SW-1]}}, srd_reg[3*SW-1 -: SW]})
                                : cr_reg[0];
    assign nv[1] = norm_sel_sum ? $signed({{(64-SW){srd_reg[2*SW-1]}}, srd_reg[2*SW-1 -: SW]})
                                : cr_reg[1];
    assign nv[2] = norm_sel_sum ? $signed({{(64-SW){srd_reg[SW-1]}}, srd_reg[SW-1:0]})
                                : cr_reg[2];

    imvn_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .vx    (nv[0]),
        .vy    (nv[1]),
        .vz    (nv[2]),
        .done  (norm_done),
        .nx    (nx),
        .ny    (ny),
        .nz    (nz),
        .ok    (nok)
    );

    always_comb
    begin
        q_pop = 1'b0;
        v_we = 1'b0;
        v_addr = AW'(q_i0);
        s_we = 1'b0;
        s_addr = AW'(q_i0);
        s_wdata = '0;
        norm_start = 1'b0;
        norm_sel_sum = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                s_we = 1'b1;
                s_addr = clr_reg;
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_kind == imvn_pkg::K_WRITE)
                    begin
                        v_we = 1'b1;
                        s_we = 1'b1;
                    end
                end
            end
            S_SREAD:
            begin
                norm_start = 1'b1;
                norm_sel_sum = 1'b1;
            end
            S_T0:
            begin
                v_addr = AW'(ia_reg);
            end
            S_T1:
            begin
                v_addr = AW'(ib_reg);
            end
            S_T2:
            begin
                v_addr = AW'(ic_reg);
            end
            S_NSTART:
            begin
                norm_start = 1'b1;
            end
            S_ACCR:
            begin
                s_addr = AW'(corner_idx);
            end
            S_ACCW:
            begin
                s_addr = AW'(corner_idx);
                s_we = 1'b1;
                s_wdata = {sat_add(srd_reg[3*SW-1 -: SW], nx),
                           sat_add(srd_reg[2*SW-1 -: SW], ny),
                           sat_add(srd_reg[SW-1:0], nz)};
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            vert_mem[v_addr] <= q_pos;
        end
        vrd_reg <= vert_mem[v_addr];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            sum_mem[s_addr] <= s_wdata;
        end
        srd_reg <= sum_mem[s_addr];
    end

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
            kind_reg <= imvn_pkg::K_WRITE;
            mul_reg <= '0;
            corner_reg <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(VERTEX_COUNT - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        kind_reg <= q_kind;
                        unique case (q_kind)
                            imvn_pkg::K_WRITE:   state_reg <= S_IDLE;
                            imvn_pkg::K_TRI:     state_reg <= S_T0;
                            imvn_pkg::K_READ:    state_reg <= S_SREAD;
                            imvn_pkg::K_BADREAD: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_SREAD:  state_reg <= S_NORM;
                S_T0:     state_reg <= S_T1;
                S_T1:     state_reg <= S_T2;
                S_T2:     state_reg <= S_T3;
                S_T3:     state_reg <= S_ERED;
                S_ERED:
                begin
                    if (!big1 && !big2)
                    begin
                        mul_reg <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    mul_reg <= mul_reg + 2'd1;
                    if (mul_reg == 2'd3)
                    begin
                        state_reg <= S_NSTART;
                    end
                end
                S_NSTART: state_reg <= S_NORM;
                S_NORM:
                begin
                    if (norm_done)
                    begin
                        corner_reg <= '0;
                        state_reg <= (kind_reg == imvn_pkg::K_READ) ? S_OUT : S_ACCR;
                    end
                end
                S_ACCR:   state_reg <= S_ACCW;
                S_ACCW:
                begin
                    corner_reg <= corner_reg + 2'd1;
                    state_reg <= (corner_reg == 2'd2) ? S_IDLE : S_ACCR;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            ia_reg <= q_i0;
            ib_reg <= q_i1;
            ic_reg <= q_i2;
        end
        if (state_reg == S_T1)
        begin
            pa_reg <= vrd_reg;
        end
        if (state_reg == S_T2)
        begin
            pb_reg <= vrd_reg;
        end
        if (state_reg == S_T3)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic signed [EW-1:0] d1;
                logic signed [EW-1:0] d2;
                d1 = coord_ext(pb_reg, k) - coord_ext(pa_reg, k);
                d2 = coord_ext(vrd_reg, k) - coord_ext(pa_reg, k);
                e1s_reg[k] <= d1[EW-1];
                e1m_reg[k] <= d1[EW-1] ? EW'(-d1) : EW'(d1);
                e2s_reg[k] <= d2[EW-1];
                e2m_reg[k] <= d2[EW-1] ? EW'(-d2) : EW'(d2);
            end
        end
        if (state_reg == S_ERED)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (big1)
                begin
                    e1m_reg[k] <= e1m_reg[k] >> 1;
                end
                if (big2)
                begin
                    e2m_reg[k] <= e2m_reg[k] >> 1;
                end
            end
        end
        if (state_reg == S_MUL)
        begin
            prod0_reg <= op_a * op_b;
            prod1_reg <= op_c * op_d;
            if (mul_reg != 2'd0)
            begin
                cr_reg[mul_reg - 2'd1] <= cr_next;
            end
        end
        if (out_load)
        begin
            if (kind_reg == imvn_pkg::K_BADREAD)
            begin
                out_x_reg <= '0;
                out_y_reg <= '0;
                out_z_reg <= '0;
                out_ok_reg <= 1'b0;
            end
            else
            begin
                out_x_reg <= nx;
                out_y_reg <= ny;
                out_z_reg <= nz;
                out_ok_reg <= nok;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign normal_x = out_x_reg;
    assign normal_y = out_y_reg;
    assign normal_z = out_z_reg;
    assign normal_valid = out_ok_reg;
endmodule

FILE: rtl/core/indexed_mesh_vertex_normals_unit.sv
`timescale 1ns / 1ps
// Smooth per-vertex normals of an indexed triangle mesh.
// The input channel (in_valid/in_stall) carries one command per transfer: a vertex
// write, a triangle, or a normal read. Only a normal read produces a transfer on the
// output channel (out_valid/out_stall), with a Q1.14 unit normal and a valid flag.
// Accepted commands enter a four-entry queue; in_stall rises only when it is full.
// The back end executes one command at a time from single-port vertex and sum memories.
// A normal read and a triangle both run the normalizer: a one-bit-per-cycle square root
// and a restoring divider that is run once for each of the three components.
// After reset a pass clears all VERTEX_COUNT entries of the sum memory; commands are
// queued but not executed until the pass is done. Vertex positions are undefined
// until written.
// While the receiver stalls, the finished result is held in the output register and
// the back end keeps executing commands until the next read result is ready.
module indexed_mesh_vertex_normals_unit #(
    parameter int VERTEX_COUNT = imvn_pkg::DEF_VERTEX_COUNT,
    parameter int COORD_WIDTH = imvn_pkg::DEF_COORD_WIDTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic [imvn_pkg::OP_W-1:0]  opcode,
    input  logic [imvn_pkg::IDX_W-1:0] vertex_index,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [COORD_WIDTH-1:0] pos_z,
    input  logic [imvn_pkg::IDX_W-1:0] corner_a,
    input  logic [imvn_pkg::IDX_W-1:0] corner_b,
    input  logic [imvn_pkg::IDX_W-1:0] corner_c,
    output logic out_valid,
    input  logic out_stall,
    output logic signed [imvn_pkg::NRM_W-1:0] normal_x,
    output logic signed [imvn_pkg::NRM_W-1:0] normal_y,
    output logic signed [imvn_pkg::NRM_W-1:0] normal_z,
    output logic normal_valid
);
    localparam int QW = imvn_pkg::KIND_W + 3 * imvn_pkg::IDX_W + 3 * COORD_WIDTH;

    logic [imvn_pkg::KIND_W-1:0] kind;
    logic [imvn_pkg::IDX_W-1:0]  index0;
    logic                        keep;
    logic                        q_full;
    logic                        q_empty;
    logic                        q_pop;
    logic [QW-1:0]               q_dout;

    assign in_stall = q_full;

    imvn_front #(
        .VERTEX_COUNT (VERTEX_COUNT)
    ) u_front (
        .opcode       (opcode),
        .vertex_index (vertex_index),
        .corner_a     (corner_a),
        .corner_b     (corner_b),
        .corner_c     (corner_c),
        .kind         (kind),
        .index0       (index0),
        .keep         (keep)
    );

    imvn_queue #(
        .WIDTH (QW),
        .DEPTH (imvn_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (in_valid && !q_full && keep),
        .din   ({kind, index0, corner_b, corner_c, pos_x, pos_y, pos_z}),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty),
        .full  (q_full)
    );

    imvn_back #(
        .VERTEX_COUNT (VERTEX_COUNT),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_dout       (q_dout),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .normal_z     (normal_z),
        .normal_valid (normal_valid)
    );
endmodule
